>>> rtl/core/rlm_pkg.sv
// rlm_pkg: shared types and constants of the RMS level meter.
// Depends on nothing; the top level and all rlm_* modules but rlm_checker use it.
`default_nettype none

package rlm_pkg;

  localparam int SUM_W   = 56;          // square accumulator width
  localparam int MAG_W   = 20;          // sample magnitude, up to 16 * 32768
  localparam int SQ_W    = 2 * MAG_W;   // one squared magnitude
  localparam int DIV_W   = SUM_W + 6;   // 36 * sum
  localparam int RAD_W   = 32;          // radicand once the level is known not to clip
  localparam int LVL_W   = 16;
  localparam int STEP_W  = 6;           // counts divide and root iterations

  localparam logic [1:0] FMT_PCM   = 2'd0;
  localparam logic [1:0] FMT_FLOAT = 2'd1;

  localparam logic [MAG_W-1:0] FLOAT_SAT  = MAG_W'(524288);
  localparam logic [7:0]       EXP_SAT    = 8'd131;   // |x| >= 16, inf, NaN
  localparam logic [7:0]       EXP_SHIFT0 = 8'd135;   // shift = 135 - exponent

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
    logic             fmt_ok;
  } item_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQ    = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_START = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_OUT   = 6'b100000
  } back_state_t;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_DIV  = 4'b0010,
    R_CHK  = 4'b0100,
    R_SQRT = 4'b1000
  } root_state_t;

endpackage

`default_nettype wire

>>> rtl/core/rlm_fifo.sv
// rlm_fifo: small queue of classified samples between front and back.
// Depends on rlm_pkg (item_t). DEPTH must be a power of two.
`default_nettype none

module rlm_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  rlm_pkg::item_t     push_item,
  output logic               full,
  input  wire logic          pop,
  output rlm_pkg::item_t     head_item,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rlm_pkg::item_t mem_r [DEPTH];
  logic [AW:0]    wr_ptr_r;
  logic [AW:0]    rd_ptr_r;

  assign empty     = (wr_ptr_r == rd_ptr_r);
  assign full      = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                     (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign head_item = mem_r[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rlm_front.sv
// rlm_front: format register and sample classification (PCM or float to magnitude).
// Depends on rlm_pkg; feeds rlm_fifo.
`default_nettype none

module rlm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_sample_format,
  input  wire logic          in_push,
  input  wire logic [31:0]   in_sample_word,
  input  wire logic          in_last_sample,
  input  wire logic          q_full,
  output logic               q_push,
  output rlm_pkg::item_t     q_item
);

  logic [1:0]                fmt_r;
  logic [15:0]               pcm_raw;
  logic [16:0]               pcm_mag;
  logic [7:0]                exp_f;
  logic [23:0]               mant_f;
  logic [7:0]                shift_f;
  logic [23:0]               mant_sh;
  logic [rlm_pkg::MAG_W-1:0] flt_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= rlm_pkg::FMT_PCM;
    end else if (cfg_we) begin
      fmt_r <= cfg_sample_format;
    end
  end

  // PCM: magnitude of a two's complement 16-bit word (-32768 gives 32768)
  assign pcm_raw = in_sample_word[15:0];
  assign pcm_mag = pcm_raw[15] ? (17'h10000 - {1'b0, pcm_raw}) : {1'b0, pcm_raw};

  // Float: trunc(|x| * 32768) straight from the bit pattern, saturating at |x| >= 16
  assign exp_f   = in_sample_word[30:23];
  assign mant_f  = {1'b1, in_sample_word[22:0]};
  assign shift_f = rlm_pkg::EXP_SHIFT0 - exp_f;
  assign mant_sh = mant_f >> shift_f[4:0];

  always_comb begin
    if (exp_f == 8'd0) begin
      flt_mag = '0;
    end else if (exp_f >= rlm_pkg::EXP_SAT) begin
      flt_mag = rlm_pkg::FLOAT_SAT;
    end else if (shift_f >= 8'd24) begin
      flt_mag = '0;
    end else begin
      flt_mag = mant_sh[rlm_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    q_item.last   = in_last_sample;
    q_item.fmt_ok = 1'b0;
    q_item.mag    = '0;
    unique case (fmt_r)
      rlm_pkg::FMT_PCM: begin
        q_item.fmt_ok = 1'b1;
        q_item.mag    = rlm_pkg::MAG_W'(pcm_mag);
      end
      rlm_pkg::FMT_FLOAT: begin
        q_item.fmt_ok = 1'b1;
        q_item.mag    = flt_mag;
      end
      default: begin
        q_item.fmt_ok = 1'b0;
        q_item.mag    = '0;
      end
    endcase
  end

  assign q_push = in_push && !q_full;

endmodule

`default_nettype wire

>>> rtl/core/rlm_root.sv
// rlm_root: level = min(65535, isqrt(floor(36 * sum / count))), iterative.
// Depends on rlm_pkg. Restoring divide one bit a cycle, then a 16-step root.
`default_nettype none

module rlm_root #(
  parameter int CNT_W = 17
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rlm_pkg::SUM_W-1:0]  sum,
  input  wire logic [CNT_W-1:0]           count,
  output logic                            done,
  output logic [rlm_pkg::LVL_W-1:0]       level
);

  localparam int DW = rlm_pkg::DIV_W;
  localparam int RW = rlm_pkg::RAD_W;

  rlm_pkg::root_state_t          state_r;
  logic                          done_r;
  logic [rlm_pkg::LVL_W-1:0]     level_r;
  logic [DW-1:0]                 quo_r;
  logic [CNT_W-1:0]              rem_r;
  logic [CNT_W-1:0]              dvs_r;
  logic [rlm_pkg::STEP_W-1:0]    step_r;
  logic [RW-1:0]                 op_r;
  logic [RW-1:0]                 res_r;
  logic [RW-1:0]                 one_r;

  logic [DW-1:0]                 dividend;
  logic [CNT_W:0]                rem_sh;
  logic                          qbit;
  logic [CNT_W-1:0]              rem_nxt;
  logic [RW:0]                   trial;
  logic                          take;
  logic [RW-1:0]                 res_nxt;

  assign dividend = (DW'(sum) << 5) + (DW'(sum) << 2);

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];

  assign trial   = {1'b0, res_r} + {1'b0, one_r};
  assign take    = ({1'b0, op_r} >= trial);
  assign res_nxt = take ? ((res_r >> 1) + one_r) : (res_r >> 1);

  assign done  = done_r;
  assign level = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlm_pkg::R_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        rlm_pkg::R_IDLE: begin
          if (start) begin
            if (count == '0) begin
              level_r <= '0;
              done_r  <= 1'b1;
            end else begin
              quo_r   <= dividend;
              rem_r   <= '0;
              dvs_r   <= count;
              step_r  <= rlm_pkg::STEP_W'(DW - 1);
              state_r <= rlm_pkg::R_DIV;
            end
          end
        end
        rlm_pkg::R_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= {quo_r[DW-2:0], qbit};
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= rlm_pkg::R_CHK;
          end
        end
        rlm_pkg::R_CHK: begin
          // a quotient of 2^32 or more always clips to full scale
          if (|quo_r[DW-1:RW]) begin
            level_r <= '1;
            done_r  <= 1'b1;
            state_r <= rlm_pkg::R_IDLE;
          end else begin
            op_r    <= quo_r[RW-1:0];
            res_r   <= '0;
            one_r   <= RW'(1) << (RW - 2);
            step_r  <= rlm_pkg::STEP_W'(RW / 2 - 1);
            state_r <= rlm_pkg::R_SQRT;
          end
        end
        rlm_pkg::R_SQRT: begin
          if (take) begin
            op_r <= op_r - trial[RW-1:0];
          end
          res_r  <= res_nxt;
          one_r  <= one_r >> 2;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            level_r <= res_nxt[rlm_pkg::LVL_W-1:0];
            done_r  <= 1'b1;
            state_r <= rlm_pkg::R_IDLE;
          end
        end
        default: begin
          state_r <= rlm_pkg::R_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rlm_back.sv
// rlm_back: squares, accumulates and counts samples; on a last sample runs
// rlm_root and holds the result for the output side. Depends on rlm_pkg, rlm_root.
`default_nettype none

module rlm_back #(
  parameter int MAX_SAMPLES = 65536,
  parameter int CNT_W       = 17
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  rlm_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  output logic [rlm_pkg::LVL_W-1:0]       out_level,
  output logic                            out_overflowed,
  input  wire logic                       out_take
);

  rlm_pkg::back_state_t           state_r;
  rlm_pkg::item_t                 item_r;
  logic [rlm_pkg::SQ_W-1:0]       sq_r;
  logic [rlm_pkg::SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]               count_r;
  logic                           ovf_r;
  logic                           out_valid_r;
  logic [rlm_pkg::LVL_W-1:0]      out_level_r;
  logic                           out_ovf_r;

  logic [rlm_pkg::SUM_W:0]        sum_add;
  logic                           at_max;
  logic                           root_start;
  logic                           root_done;
  logic [rlm_pkg::LVL_W-1:0]      root_level;
  logic                           slot_free;

  assign sum_add    = {1'b0, sum_r} + (rlm_pkg::SUM_W + 1)'(sq_r);
  assign at_max     = (count_r >= CNT_W'(MAX_SAMPLES));
  assign q_pop      = (state_r == rlm_pkg::ST_IDLE) && !q_empty;
  assign root_start = (state_r == rlm_pkg::ST_START);
  assign slot_free  = !out_valid_r || out_take;

  rlm_root #(
    .CNT_W (CNT_W)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .sum   (sum_r),
    .count (count_r),
    .done  (root_done),
    .level (root_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlm_pkg::ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // ST_OUT refills the slot itself when the old result leaves
      if (out_take && (state_r != rlm_pkg::ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        rlm_pkg::ST_IDLE: begin
          if (!q_empty) begin
            item_r  <= q_item;
            state_r <= rlm_pkg::ST_SQ;
          end
        end
        rlm_pkg::ST_SQ: begin
          sq_r    <= rlm_pkg::SQ_W'(item_r.mag) * rlm_pkg::SQ_W'(item_r.mag);
          state_r <= rlm_pkg::ST_ACC;
        end
        rlm_pkg::ST_ACC: begin
          // a full buffer drops the sample but a last flag still closes it
          if (at_max) begin
            ovf_r <= 1'b1;
          end else begin
            sum_r   <= sum_add[rlm_pkg::SUM_W] ? '1 : sum_add[rlm_pkg::SUM_W-1:0];
            count_r <= count_r + 1'b1;
          end
          state_r <= item_r.last ? rlm_pkg::ST_START : rlm_pkg::ST_IDLE;
        end
        rlm_pkg::ST_START: begin
          state_r <= rlm_pkg::ST_ROOT;
        end
        rlm_pkg::ST_ROOT: begin
          if (root_done) begin
            state_r <= rlm_pkg::ST_OUT;
          end
        end
        rlm_pkg::ST_OUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_level_r <= item_r.fmt_ok ? root_level : '0;
            out_ovf_r   <= ovf_r;
            sum_r       <= '0;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= rlm_pkg::ST_IDLE;
          end
        end
        default: begin
          state_r <= rlm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_overflowed = out_ovf_r;

endmodule

`default_nettype wire

>>> rtl/core/rms_level_meter.sv
// rms_level_meter: top level of the RMS level meter.
// Depends on rlm_pkg, rlm_front, rlm_fifo, rlm_back (and rlm_root below it).
//
//   channel  | ports                                   | beat taken when
//   ---------+-----------------------------------------+-------------------------
//   input    | in_push, in_full, in_sample_word,       | in_push  && !in_full
//            | in_last_sample                          |
//   result   | out_empty, out_pop, out_level,          | out_pop  && !out_empty
//            | out_overflowed                          |
//   config   | cfg_we, cfg_sample_format               | cfg_we
//
// The front converts each sample to a magnitude in the cycle it arrives and
// writes it into a QUEUE_DEPTH-entry queue, so it takes one beat per cycle
// until the queue fills. The back drains the queue one sample at a time: it
// pops, squares and accumulates a sample before it pops the next. A last
// sample adds the level computation: a start state, a restoring divide of
// 36 * sum by the count, a check, an integer root (skipped when the level
// clips), the hand-back of the level and the load of the result register;
// the divide is the longest of these steps.
// One result register holds the level until popped; the back stalls there
// only if an older result waits.
// Reset is synchronous and active low; it clears the queue, the accumulator,
// the result register and sets the format to 16-bit PCM.
`default_nettype none

module rms_level_meter #(
  parameter int MAX_SAMPLES = 65536,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_sample_format,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic [31:0]  in_sample_word,
  input  wire logic         in_last_sample,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [15:0]       out_level,
  output logic              out_overflowed
);

  // wide enough to hold MAX_SAMPLES itself
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  rlm_pkg::item_t q_wr_item;
  rlm_pkg::item_t q_rd_item;
  logic           res_valid;

  rlm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_sample_format (cfg_sample_format),
    .in_push           (in_push),
    .in_sample_word    (in_sample_word),
    .in_last_sample    (in_last_sample),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_wr_item)
  );

  rlm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_rd_item),
    .empty     (q_empty)
  );

  rlm_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (q_rd_item),
    .q_pop          (q_pop),
    .out_valid      (res_valid),
    .out_level      (out_level),
    .out_overflowed (out_overflowed),
    .out_take       (out_pop && res_valid)
  );

  // hold off the producer while the queue is full
  assign in_full   = q_full;
  assign out_empty = !res_valid;

endmodule

`default_nettype wire

>>> rtl/core/rlm_checker.sv
// rlm_checker: port-level checks of rms_level_meter, bound to the top level.
// Depends on rms_level_meter's port list only.
`default_nettype none

module rlm_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  input  wire logic         in_full,
  input  wire logic         out_empty,
  input  wire logic         out_pop,
  input  wire logic [15:0]  out_level,
  input  wire logic         out_overflowed
);

  // reset drops any held result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result still shown after reset");

  // reset drains the input queue
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  // a result not popped stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_level) && $stable(out_overflowed))
    else $error("waiting result changed before pop");

  // a result needs at least one beat in; none can appear on the edge after reset
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 (rst_n && !(in_push && !in_full)) |=> out_empty)
    else $error("result shown without any input");

endmodule

bind rms_level_meter rlm_checker u_rlm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_level      (out_level),
  .out_overflowed (out_overflowed)
);

`default_nettype wire
